@@ rtl/core/keyed_fifo_table_core_macros.svh @@
// Assertion helpers shared by the keyed FIFO table RTL.
// Same-cycle and next-cycle implications, both disabled during reset.
`ifndef KEYED_FIFO_TABLE_CORE_MACROS_SVH
`define KEYED_FIFO_TABLE_CORE_MACROS_SVH

// cons must hold in the cycle where ante holds
`define KFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define KFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/kft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed FIFO table package
// Command and status codes, default sizes and the control/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package kft_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 64;
  localparam int CMD_W            = 3;
  localparam int KEY_W            = 32;
  localparam int STATUS_W         = 2;

  localparam logic [CMD_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] OP_POP   = 3'd1;
  localparam logic [CMD_W-1:0] OP_FIND  = 3'd2;
  localparam logic [CMD_W-1:0] OP_TAKE  = 3'd3;
  localparam logic [CMD_W-1:0] OP_REKEY = 3'd4;
  localparam logic [CMD_W-1:0] OP_CLEAR = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic scan_next;
    logic hit;
    logic rekey_write;
    logic shift_step;
    logic shift_done;
    logic do_push;
    logic do_clear;
    logic set_ok;
    logic set_full;
    logic publish;
  } dp_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             occ_zero;
    logic             occ_full;
    logic             scan_hit;
    logic             scan_last;
    logic             shift_last;
    logic             out_hold;
  } dp_stat_t;

endpackage

@@ rtl/core/kft_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed FIFO table command channel
// Valid/ready channel carrying one command with its key and payload.
// ----------------------------------------------------------------------------
interface kft_req_if #(
  parameter int PAYLOAD_BITS = kft_pkg::PAYLOAD_BITS_DEF
) ();
  import kft_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] new_key;
  logic [PAYLOAD_BITS-1:0] payload_in;

  modport source (output valid, cmd, key, new_key, payload_in, input ready);
  modport sink   (input valid, cmd, key, new_key, payload_in, output ready);
endinterface

@@ rtl/core/kft_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed FIFO table result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface kft_rsp_if #(
  parameter int CAPACITY     = kft_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = kft_pkg::PAYLOAD_BITS_DEF
) ();
  import kft_pkg::*;

  logic                             valid;
  logic                             ready;
  logic [STATUS_W-1:0]              status;
  logic [PAYLOAD_BITS-1:0]          payload_out;
  logic [$clog2(CAPACITY+1)-1:0]    entry_count;
  logic                             is_empty;

  modport source (output valid, status, payload_out, entry_count, is_empty, input ready);
  modport sink   (input valid, status, payload_out, entry_count, is_empty, output ready);
endinterface

@@ rtl/core/kft_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed FIFO table RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/kft_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed FIFO table datapath
// Entry stores, occupancy, scan and compaction indexes, and the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
`include "keyed_fifo_table_core_macros.svh"

module kft_datapath #(
  parameter int CAPACITY     = kft_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = kft_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kft_pkg::dp_ctrl_t                 ctrl,
  output kft_pkg::dp_stat_t                 stat,
  input  logic [kft_pkg::CMD_W-1:0]         cmd,
  input  logic signed [kft_pkg::KEY_W-1:0]  key,
  input  logic signed [kft_pkg::KEY_W-1:0]  new_key,
  input  logic [PAYLOAD_BITS-1:0]           payload_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kft_pkg::STATUS_W-1:0]      status,
  output logic [PAYLOAD_BITS-1:0]           payload_out,
  output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
  output logic                              is_empty
);
  import kft_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [CMD_W-1:0]        op;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] nkey_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [CW-1:0]           occ;
  logic [CW-1:0]           cmp_idx;
  logic [CW-1:0]           wr_idx;
  logic [STATUS_W-1:0]     res_status;
  logic [PAYLOAD_BITS-1:0] res_payload;

  logic [CW-1:0]           cmp_inc;
  logic [CW-1:0]           wr_inc;
  logic [CW-1:0]           wr_inc2;

  logic [AW-1:0]           rd_addr;
  logic                    key_we;
  logic [AW-1:0]           key_waddr;
  logic [KEY_W-1:0]        key_wdata;
  logic [KEY_W-1:0]        key_rdata;
  logic                    pay_we;
  logic [AW-1:0]           pay_waddr;
  logic [PAYLOAD_BITS-1:0] pay_wdata;
  logic [PAYLOAD_BITS-1:0] pay_rdata;

  assign cmp_inc = cmp_idx + CW'(1);
  assign wr_inc  = wr_idx + CW'(1);
  assign wr_inc2 = wr_idx + CW'(2);

  assign stat.op         = op;
  assign stat.occ_zero   = (occ == '0);
  assign stat.occ_full   = (occ >= CW'(CAPACITY));
  assign stat.scan_hit   = (op == OP_POP) || (key_rdata == key_q);
  assign stat.scan_last  = (cmp_inc >= occ);
  assign stat.shift_last = (wr_inc >= occ);
  assign stat.out_hold   = out_valid && !out_ready;

  // Read one entry ahead: the scan looks at cmp_idx while cmp_idx+1 is
  // fetched, and compaction fetches two above the slot being written.
  always_comb begin
    if (ctrl.scan_start) begin
      rd_addr = '0;
    end else if (ctrl.shift_step) begin
      rd_addr = wr_inc2[AW-1:0];
    end else begin
      rd_addr = cmp_inc[AW-1:0];
    end
  end

  always_comb begin
    key_we    = ctrl.do_push || ctrl.rekey_write || ctrl.shift_step;
    key_waddr = wr_idx[AW-1:0];
    key_wdata = key_rdata;
    pay_we    = ctrl.do_push || ctrl.shift_step;
    pay_waddr = wr_idx[AW-1:0];
    pay_wdata = pay_rdata;
    if (ctrl.do_push) begin
      key_waddr = occ[AW-1:0];
      key_wdata = key_q;
      pay_waddr = occ[AW-1:0];
      pay_wdata = pay_q;
    end else if (ctrl.rekey_write) begin
      key_waddr = cmp_idx[AW-1:0];
      key_wdata = nkey_q;
    end
  end

  kft_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (key_wdata),
    .rd_addr (rd_addr),
    .rd_data (key_rdata)
  );

  kft_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (CAPACITY)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (pay_we),
    .wr_addr (pay_waddr),
    .wr_data (pay_wdata),
    .rd_addr (rd_addr),
    .rd_data (pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.do_push) begin
        occ <= occ + CW'(1);
      end else if (ctrl.do_clear) begin
        occ <= '0;
      end else if (ctrl.shift_done) begin
        occ <= occ - CW'(1);
      end
      if (ctrl.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      op          <= cmd;
      key_q       <= key;
      nkey_q      <= new_key;
      pay_q       <= payload_in;
      res_status  <= ST_MISS;
      res_payload <= '0;
    end
    if (ctrl.set_ok) begin
      res_status <= ST_OK;
    end else if (ctrl.set_full) begin
      res_status <= ST_FULL;
    end
    if (ctrl.scan_start) begin
      cmp_idx <= '0;
    end else if (ctrl.scan_next) begin
      cmp_idx <= cmp_inc;
    end
    if (ctrl.hit) begin
      wr_idx      <= cmp_idx;
      res_payload <= pay_rdata;
    end else if (ctrl.shift_step) begin
      wr_idx <= wr_inc;
    end
    if (ctrl.publish) begin
      status      <= res_status;
      payload_out <= res_payload;
      entry_count <= occ;
      is_empty    <= (occ == '0);
    end
  end

  `KFT_ASSERT_SAME(a_occ_bound, clk, rst, 1'b1, occ <= CW'(CAPACITY), "occupancy over capacity")
  `KFT_ASSERT_SAME(a_push_room, clk, rst, ctrl.do_push, occ < CW'(CAPACITY), "push into full table")
  `KFT_ASSERT_SAME(a_shift_range, clk, rst, ctrl.shift_step, wr_inc < occ, "compaction past tail")
  `KFT_ASSERT_SAME(a_empty_flag, clk, rst, out_valid, is_empty == (entry_count == '0), "empty flag disagrees with count")
  `KFT_ASSERT_NEXT(a_count_out, clk, rst, ctrl.publish, entry_count == occ, "result count differs from occupancy")

endmodule

@@ rtl/core/kft_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed FIFO table controller
// Sequences each command: dispatch, key scan, compaction and result hand-off.
// ----------------------------------------------------------------------------
module kft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kft_pkg::dp_stat_t stat,
  output kft_pkg::dp_ctrl_t ctrl
);
  import kft_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    ctrl       = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FINISH;
        case (stat.op)
          OP_PUSH: begin
            if (stat.occ_full) begin
              ctrl.set_full = 1'b1;
            end else begin
              ctrl.do_push = 1'b1;
              ctrl.set_ok  = 1'b1;
            end
          end
          OP_POP, OP_FIND, OP_TAKE, OP_REKEY: begin
            if (!stat.occ_zero) begin
              ctrl.scan_start = 1'b1;
              state_next      = S_SCAN;
            end
          end
          OP_CLEAR: begin
            if (!stat.occ_zero) begin
              ctrl.do_clear = 1'b1;
              ctrl.set_ok   = 1'b1;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          ctrl.hit    = 1'b1;
          ctrl.set_ok = 1'b1;
          if (stat.op == OP_REKEY) begin
            ctrl.rekey_write = 1'b1;
          end
          if (stat.op == OP_TAKE || stat.op == OP_POP) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_FINISH;
          end
        end else if (stat.scan_last) begin
          state_next = S_FINISH;
        end else begin
          ctrl.scan_next = 1'b1;
        end
      end
      S_SHIFT: begin
        // close the gap one entry per cycle, then drop the tail
        if (stat.shift_last) begin
          ctrl.shift_done = 1'b1;
          state_next      = S_FINISH;
        end else begin
          ctrl.shift_step = 1'b1;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!stat.out_hold) begin
          ctrl.publish = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/keyed_fifo_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed FIFO table core
// Ordered queue of keyed records with push, pop, find, take, rekey, clear.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command (cmd, key, new_key, payload_in); rsp returns one
//   result per command (status, payload_out, entry_count, is_empty). Both are
//   valid/ready channels; a transfer happens when valid and ready are high.
//   One command is in flight at a time. Push, clear, unknown codes and any
//   search on an empty table go from dispatch straight to the result. Find,
//   rekey and take scan from the oldest entry up to the oldest match (or to
//   the last entry on a miss); pop takes the oldest entry, and pop and take
//   then compact the entries behind it. The key scan and compaction each walk
//   the entry RAMs one entry per cycle.
//   req.ready returns at the same edge that posts the result.
//   The result sits in an output register: a stalled receiver does not stop
//   the next command from being accepted and worked on; that command's result
//   waits until the register is taken.
//   Reset empties the table and clears rsp.valid; no RAM clearing is needed.
// ----------------------------------------------------------------------------
module keyed_fifo_table_core #(
  parameter int CAPACITY     = kft_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = kft_pkg::PAYLOAD_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  kft_req_if.sink  req,
  kft_rsp_if.source rsp
);
  import kft_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  kft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  kft_datapath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .cmd         (req.cmd),
    .key         (req.key),
    .new_key     (req.new_key),
    .payload_in  (req.payload_in),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .payload_out (rsp.payload_out),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty)
  );

endmodule
